// ===== hdl/tlg_pkg.sv =====
`default_nettype none

package tlg_pkg;

    // Widest row the board supports
    localparam int C_MAX_COLS = 64;

    // Width of the reported living count and its ceiling
    localparam int          C_LIV_W      = 13;
    localparam logic [12:0] C_LIVING_MAX = 13'h1FFF;

    // Neighbor counts of the B3/S23 rule
    localparam logic [3:0] C_BIRTH_N   = 4'd3;
    localparam logic [3:0] C_SURVIVE_N = 4'd2;

    // Request function codes; any other code acts as a read
    localparam logic [1:0] C_FUNC_WRITE   = 2'd0;
    localparam logic [1:0] C_FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] C_FUNC_READ    = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       cell_value;
    } t_req;

    typedef struct packed {
        logic        cell_state;
        logic [31:0] generation_count;
        logic [12:0] living_count;
    } t_rsp;

    // Count set bits of one row through a six-level adder tree
    function automatic logic [6:0] f_popcount64(input logic [63:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++) begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/toroidal_life_generation_step_core.sv =====
// Every function makes one full pass of the row chain, one row per cycle, then the
// S_DONE state settles the counts and registers the result strobe; a new request is
// taken only once the block is back in idle.
// The result is a one-cycle strobe; the receiver cannot stall it.
// Reset (synchronous, active low) clears the board, generation and living counts.
`default_nettype none

module toroidal_life_generation_step_core
    import tlg_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CMPW  = ((RW > 6) ? RW : 6) + 1;
    localparam int TOT_W = $clog2(ROWS * COLS + 1);
    localparam int SW    = (TOT_W > C_LIV_W) ? TOT_W : C_LIV_W;
    localparam logic [RW-1:0] T_LAST = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [RW-1:0]   r_t, n_t;
    t_req            r_req, n_req;
    logic [COLS-1:0] r_up, n_up;
    logic [COLS-1:0] r_first, n_first;
    logic [TOT_W-1:0] r_acc, n_acc;
    logic [TOT_W-1:0] r_total, n_total;
    logic [31:0]     r_gen, n_gen;
    logic            r_bit, n_bit;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;

    logic [COLS-1:0] w_row [ROWS];
    logic [COLS-1:0] w_tail_in;
    logic [COLS-1:0] w_dn;
    logic [COLS-1:0] w_new;
    logic [COLS-1:0] w_mod;
    logic            w_shift;
    logic            w_col_ok;
    logic            w_hit;
    logic [CW-1:0]   w_col;
    logic            w_is_adv;
    logic            w_is_wr;
    logic [TOT_W-1:0] w_tail_pop;
    logic [TOT_W-1:0] w_tot_new;
    logic [SW-1:0]   w_tot_ext;

    // Row chain: cell k takes the row of cell k+1, the last cell takes the new row
    for (genvar k = 0; k < ROWS; k++) begin : g_cell
        if (k == ROWS - 1) begin : g_tail
            tlg_row_cell #(.COLS(COLS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_row   (w_tail_in),
                .o_row   (w_row[k])
            );
        end else begin : g_body
            tlg_row_cell #(.COLS(COLS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_row   (w_row[k+1]),
                .o_row   (w_row[k])
            );
        end
    end

    // Row below the head of the chain; on the last row it wraps to the saved first row
    assign w_dn = (r_t == T_LAST) ? r_first : w_row[1];

    tlg_row_rule #(.COLS(COLS)) u_rule (
        .i_up   (r_up),
        .i_cur  (w_row[0]),
        .i_dn   (w_dn),
        .o_next (w_new)
    );

    // Decode the held request
    assign w_is_adv = (r_req.func == C_FUNC_ADVANCE);
    assign w_is_wr  = (r_req.func == C_FUNC_WRITE);
    assign w_col_ok = ({1'b0, r_req.cell_col} < 7'(COLS));
    assign w_col    = r_req.cell_col[CW-1:0];
    assign w_hit    = w_col_ok && (CMPW'(r_t) == CMPW'(r_req.cell_row));
    assign w_shift  = (r_state == S_RUN);

    // Head row with the addressed bit overwritten
    always_comb begin
        w_mod        = w_row[0];
        w_mod[w_col] = r_req.cell_value;
    end

    // Feed the tail: new rows on advance, the written row on a write hit, rotated rows otherwise
    always_comb begin
        if (w_is_adv) begin
            w_tail_in = w_new;
        end else if (w_is_wr && w_hit) begin
            w_tail_in = w_mod;
        end else begin
            w_tail_in = w_row[0];
        end
    end

    assign w_tail_pop = TOT_W'(f_popcount64(C_MAX_COLS'(w_row[ROWS-1])));
    assign w_tot_new  = w_is_adv ? (r_acc + w_tail_pop) : r_total;
    assign w_tot_ext  = SW'(w_tot_new);

    // Sequence one pass of the chain per request
    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_req   = r_req;
        n_up    = r_up;
        n_first = r_first;
        n_acc   = r_acc;
        n_total = r_total;
        n_gen   = r_gen;
        n_bit   = r_bit;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_up    = w_row[ROWS-1];
                    n_first = w_row[0];
                    n_t     = '0;
                    n_acc   = '0;
                    n_bit   = 1'b0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_up = w_row[0];
                if (w_is_adv && (r_t != '0)) begin
                    n_acc = r_acc + w_tail_pop;
                end
                if (w_hit) begin
                    if (w_is_adv) begin
                        n_bit = w_new[w_col];
                    end else if (w_is_wr) begin
                        n_bit = r_req.cell_value;
                        if (w_row[0][w_col] != r_req.cell_value) begin
                            n_total = r_req.cell_value ? r_total + 1'b1 : r_total - 1'b1;
                        end
                    end else begin
                        n_bit = w_row[0][w_col];
                    end
                end
                if (r_t == T_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            S_DONE: begin
                n_total                = w_tot_new;
                n_gen                  = w_is_adv ? r_gen + 32'd1 : r_gen;
                n_rsp.cell_state       = r_bit;
                n_rsp.generation_count = n_gen;
                n_rsp.living_count     = (w_tot_ext > SW'(C_LIVING_MAX)) ?
                                         C_LIVING_MAX : w_tot_ext[C_LIV_W-1:0];
                n_done                 = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control and counters; payload registers need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_gen   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_gen   <= n_gen;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_req   <= n_req;
        r_up    <= n_up;
        r_first <= n_first;
        r_acc   <= n_acc;
        r_bit   <= n_bit;
        r_rsp   <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ===== hdl/tlg_row_cell.sv =====
`default_nettype none

module tlg_row_cell
    import tlg_pkg::*;
#(
    parameter int COLS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire logic [COLS-1:0] i_row,
    output logic      [COLS-1:0] o_row
);

    logic [COLS-1:0] r_row;

    // Clear at reset; take the neighbor's row on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_shift) begin
            r_row <= i_row;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

// ===== hdl/tlg_row_rule.sv =====
`default_nettype none

module tlg_row_rule
    import tlg_pkg::*;
#(
    parameter int COLS = 64
) (
    input  wire logic [COLS-1:0] i_up,
    input  wire logic [COLS-1:0] i_cur,
    input  wire logic [COLS-1:0] i_dn,
    output logic      [COLS-1:0] o_next
);

    // Apply B3/S23 to every column, wrapping left and right edges
    for (genvar c = 0; c < COLS; c++) begin : g_col
        localparam int LF = (c == 0) ? COLS - 1 : c - 1;
        localparam int RT = (c == COLS - 1) ? 0 : c + 1;
        logic [3:0] w_n;

        assign w_n = {3'b0, i_up[LF]} + {3'b0, i_up[c]} + {3'b0, i_up[RT]}
                   + {3'b0, i_cur[LF]} + {3'b0, i_cur[RT]}
                   + {3'b0, i_dn[LF]} + {3'b0, i_dn[c]} + {3'b0, i_dn[RT]};
        assign o_next[c] = (w_n == C_BIRTH_N) || (i_cur[c] && (w_n == C_SURVIVE_N));
    end

endmodule

`default_nettype wire

// ===== dv/tb_toroidal_life_generation_step_core.sv =====
`default_nettype none

module tb_toroidal_life_generation_step_core;
    import tlg_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;

    // Function code with no defined operation; it answers like a read
    localparam logic [1:0] C_FUNC_SPARE = 2'd3;

    localparam int C_ITEMS       = 1050;
    localparam int C_CALM_ITEMS  = 150;
    localparam int C_QUIET_LIMIT = 2000;
    localparam int C_DRAIN       = ROWS + 4;

    // Track the board and score every response against the predicted one
    class life_scoreboard;
        logic [C_MAX_COLS-1:0] cells [ROWS];
        logic [31:0]           generation;
        int unsigned           live_total;
        t_rsp                  awaited [$];
        int unsigned           mismatches;

        function new();
            foreach (cells[r]) cells[r] = '0;
            generation = '0;
            live_total = 0;
            mismatches = 0;
        endfunction

        // Compute every cell of the next generation from the old board
        function void advance_generation();
            logic [C_MAX_COLS-1:0] nxt [ROWS];
            int          up, dn, lf, rt, n;
            int unsigned total;
            total = 0;
            for (int r = 0; r < ROWS; r++) begin
                up     = (r == 0) ? ROWS - 1 : r - 1;
                dn     = (r == ROWS - 1) ? 0 : r + 1;
                nxt[r] = '0;
                for (int c = 0; c < COLS; c++) begin
                    lf = (c == 0) ? COLS - 1 : c - 1;
                    rt = (c == COLS - 1) ? 0 : c + 1;
                    n  = cells[up][lf] + cells[up][c] + cells[up][rt]
                       + cells[r][lf] + cells[r][rt]
                       + cells[dn][lf] + cells[dn][c] + cells[dn][rt];
                    if (cells[r][c] ? (n == C_SURVIVE_N || n == C_BIRTH_N)
                                    : (n == C_BIRTH_N)) begin
                        nxt[r][c] = 1'b1;
                        total++;
                    end
                end
            end
            cells      = nxt;
            generation = generation + 32'd1;
            live_total = total;
        endfunction

        // Apply an accepted request and queue the response it must produce
        function void note_request(t_req req);
            bit   on_board;
            t_rsp want;
            on_board = (req.cell_row < ROWS) && (req.cell_col < COLS);
            case (req.func)
                C_FUNC_WRITE: begin
                    if (on_board && cells[req.cell_row][req.cell_col] != req.cell_value) begin
                        cells[req.cell_row][req.cell_col] = req.cell_value;
                        if (req.cell_value) live_total++;
                        else live_total--;
                    end
                end
                C_FUNC_ADVANCE: advance_generation();
                default: ;
            endcase
            want.cell_state       = on_board ? cells[req.cell_row][req.cell_col] : 1'b0;
            want.generation_count = generation;
            want.living_count     = (live_total > C_LIVING_MAX) ? C_LIVING_MAX
                                                                : C_LIV_W'(live_total);
            awaited.push_back(want);
        endfunction

        // Compare one response with the oldest outstanding prediction
        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                $error("response with no request outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.cell_state !== want.cell_state) begin
                $error("cell_state: expected %0d, actual %0d", want.cell_state, got.cell_state);
                mismatches++;
            end
            if (got.generation_count !== want.generation_count) begin
                $error("generation_count: expected %0d, actual %0d",
                       want.generation_count, got.generation_count);
                mismatches++;
            end
            if (got.living_count !== want.living_count) begin
                $error("living_count: expected %0d, actual %0d",
                       want.living_count, got.living_count);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    life_scoreboard sb = new();

    int items_sent = 0;
    int win_row, win_col, win_size;

    toroidal_life_generation_step_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Score each response strobe at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) sb.check_response(o_rsp);
    end

    // Abort when neither a request nor a response moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < C_QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_done === 1'b1) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Present one request and hold it until the block takes it
    task automatic drive_request(input t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(req);
        items_sent++;
    endtask

    task automatic send_cell(input logic [1:0] func, input int row, input int col,
                             input logic value);
        t_req req;
        req.func       = func;
        req.cell_row   = row[5:0];
        req.cell_col   = col[5:0];
        req.cell_value = value;
        drive_request(req);
    endtask

    // Drop start for a number of cycles
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and hold off until every response has come back
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    // Move the active window, favoring spots that straddle the wrap edges
    task automatic pick_window();
        win_size = $urandom_range(3, 8);
        win_row  = ($urandom_range(0, 1) != 0) ? (ROWS - 4 + $urandom_range(0, 7)) % ROWS
                                               : $urandom_range(0, ROWS - 1);
        win_col  = ($urandom_range(0, 1) != 0) ? (COLS - 4 + $urandom_range(0, 7)) % COLS
                                               : $urandom_range(0, COLS - 1);
    endtask

    // Build a random request, mostly seeding and evolving the active window
    function automatic t_req random_request();
        t_req req;
        int   dice;
        dice           = $urandom_range(0, 99);
        req.cell_row   = 6'((win_row + $urandom_range(0, win_size - 1)) % ROWS);
        req.cell_col   = 6'((win_col + $urandom_range(0, win_size - 1)) % COLS);
        req.cell_value = 1'($urandom_range(0, 1));
        if (dice < 40) begin
            req.func       = C_FUNC_WRITE;
            req.cell_value = ($urandom_range(0, 9) < 7);
        end else if (dice < 60) begin
            req.func = C_FUNC_ADVANCE;
        end else if (dice < 80) begin
            req.func = C_FUNC_READ;
        end else if (dice < 85) begin
            req.func = C_FUNC_SPARE;
        end else begin
            // Noise anywhere on the board
            req.func     = 2'($urandom_range(0, 3));
            req.cell_row = 6'($urandom_range(0, 63));
            req.cell_col = 6'($urandom_range(0, 63));
        end
        return req;
    endfunction

    initial begin
        int left_in_window;

        // Hold reset before releasing it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Read the cleared board
        send_cell(C_FUNC_READ, 0, 0, 1'b1);
        // Corner block that touches itself only across both wrap edges
        send_cell(C_FUNC_WRITE, 0, 0, 1'b1);
        send_cell(C_FUNC_WRITE, 0, 63, 1'b1);
        send_cell(C_FUNC_WRITE, 63, 0, 1'b1);
        send_cell(C_FUNC_WRITE, 63, 63, 1'b1);
        // Write a value the cell already holds
        send_cell(C_FUNC_WRITE, 0, 0, 1'b1);
        send_cell(C_FUNC_ADVANCE, 63, 63, 1'b0);
        send_cell(C_FUNC_SPARE, 63, 63, 1'b0);
        // Kill one corner, twice, then let the L grow back into a block
        send_cell(C_FUNC_WRITE, 63, 63, 1'b0);
        send_cell(C_FUNC_WRITE, 63, 63, 1'b0);
        send_cell(C_FUNC_ADVANCE, 63, 63, 1'b1);
        send_cell(C_FUNC_READ, 63, 63, 1'b0);
        // Blinker straddling the column wrap
        send_cell(C_FUNC_WRITE, 10, 63, 1'b1);
        send_cell(C_FUNC_WRITE, 10, 0, 1'b1);
        send_cell(C_FUNC_WRITE, 10, 1, 1'b1);
        send_cell(C_FUNC_ADVANCE, 9, 0, 1'b0);
        send_cell(C_FUNC_ADVANCE, 10, 0, 1'b1);
        send_cell(C_FUNC_READ, 11, 0, 1'b1);
        // Spare code must not write
        send_cell(C_FUNC_SPARE, 20, 20, 1'b1);
        send_cell(C_FUNC_READ, 20, 20, 1'b0);
        send_cell(C_FUNC_WRITE, 32, 31, 1'b1);
        send_cell(C_FUNC_READ, 32, 31, 1'b0);
        wait_for_drain();

        // Random phase with idle bursts until the calm tail
        left_in_window = 0;
        while (items_sent < C_ITEMS) begin
            if (left_in_window == 0) begin
                pick_window();
                left_in_window = $urandom_range(25, 60);
            end
            left_in_window--;
            if (items_sent == C_ITEMS / 2) wait_for_drain();
            else if (items_sent < C_ITEMS - C_CALM_ITEMS && $urandom_range(0, 5) == 0)
                idle_for($urandom_range(1, 13));
            drive_request(random_request());
        end

        // Drain outstanding responses, then watch for strays
        wait_for_drain();
        repeat (C_DRAIN) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
